@@ sv/ctl_pkg.sv @@
// Shared types and constants for the cache tag lookup block.
// No dependencies.
package ctl_pkg;

  localparam int ADDR_W     = 32;
  localparam int CNT_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 3;
  localparam int BLK_LOG2_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_MAP_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORGANIZATION = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_LOG2  = 2'd2;

  localparam logic [BLK_LOG2_W-1:0] BLK_LOG2_RST = 3'd6;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic              access_kind;
  } req_t;

  typedef struct packed {
    logic             hit;
    logic [CNT_W-1:0] access_total;
    logic [CNT_W-1:0] hit_total;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DM_RD,
    ST_DM_CMP,
    ST_FA_SCAN,
    ST_FA_FILL,
    ST_FINISH
  } state_e;

endpackage

@@ sv/ctl_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module ctl_ram #(
  parameter int WIDTH = 26,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/cache_tag_lookup_fifo.sv @@
// Cache tag lookup, direct mapped or fully associative with FIFO replacement.
// Uses ctl_pkg and ctl_ram (tag store).
// Direct mapped reads and compares one slot; associative scans the region
// from its base until a hit or its last entry, then fills a line on a miss.
// One tag comparator walks the tag RAM an entry a cycle; next start is taken
// in the done cycle. The receiver cannot stall; done_o is a one-cycle strobe.
// Reset clears valid bits, pointers, counters and config at once; no sweep.
module cache_tag_lookup_fifo #(
  parameter int MAX_LINES  = 64,
  parameter int LINE_BYTES = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  ctl_pkg::req_t                     req_i,
  output logic                              done_o,
  output ctl_pkg::res_t                     result_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ctl_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [ctl_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import ctl_pkg::*;

  localparam int LW    = $clog2(MAX_LINES);
  localparam int TOP   = $clog2(MAX_LINES + 1) - 1;
  localparam int OB    = $clog2(LINE_BYTES);
  localparam int TAG_W = ADDR_W - OB;
  localparam int HALF  = (1 << TOP) / 2;

  state_e state_q, state_d;

  logic                  map_mode_q, organization_q;
  logic [BLK_LOG2_W-1:0] blk_log2_q;
  logic [MAX_LINES-1:0]  line_vld_q, line_vld_d;
  logic [LW-1:0]         fifo1_q, fifo1_d, fifo2_q, fifo2_d;
  logic [CNT_W-1:0]      acc_q, acc_d, hits_q, hits_d;
  logic                  done_q, done_d;
  logic                  iss_q, iss_d, pend_q, pend_d;
  logic                  have_free_q, have_free_d;
  logic                  hit_q, hit_d;

  logic [LW-1:0]         idx_q, idx_d, pidx_q, pidx_d, free_q, free_d;
  logic [LW-1:0]         base_q, base_d, last_q, last_d;
  logic [TAG_W-1:0]      tag_q, tag_d;
  logic                  second_q, second_d;

  logic                  ram_we, ram_re;
  logic [LW-1:0]         ram_waddr;
  logic [TAG_W-1:0]      ram_rdata;

  logic                  accept;
  logic                  cmp_hit;

  assign accept      = start && !busy;
  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign cmp_hit     = line_vld_q[pidx_q] && (ram_rdata == tag_q);

  ctl_ram #(
    .WIDTH (TAG_W),
    .DEPTH (MAX_LINES)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (tag_q),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = map_mode_q ? ST_FA_SCAN : ST_DM_RD;
        end
      end
      ST_DM_RD:  state_d = ST_DM_CMP;
      ST_DM_CMP: state_d = ST_FINISH;
      ST_FA_SCAN: begin
        if (pend_q && cmp_hit) begin
          state_d = ST_FINISH;
        end else if (pend_q && (pidx_q == last_q)) begin
          state_d = ST_FA_FILL;
        end
      end
      ST_FA_FILL: state_d = ST_FINISH;
      ST_FINISH:  state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    logic [BLK_LOG2_W-1:0] lb, ib;
    logic [LW:0]           size, last_w;
    logic [LW-1:0]         base, slot, ptr_raw, ptr;
    logic [TAG_W-1:0]      off;
    logic                  split;

    split = organization_q;
    if (blk_log2_q < BLK_LOG2_W'(1)) begin
      lb = BLK_LOG2_W'(1);
    end else if (blk_log2_q > BLK_LOG2_W'(TOP)) begin
      lb = BLK_LOG2_W'(TOP);
    end else begin
      lb = blk_log2_q;
    end
    ib     = split ? lb - BLK_LOG2_W'(1) : lb;
    size   = (LW + 1)'(1) << ib;
    base   = (split && req_i.access_kind) ? size[LW-1:0] : '0;
    last_w = {1'b0, base} + size - (LW + 1)'(1);
    off    = req_i.address[ADDR_W-1:OB];
    slot   = base | (off[LW-1:0] & (size[LW-1:0] - LW'(1)));

    ptr_raw = second_q ? fifo2_q : fifo1_q;
    ptr     = ((ptr_raw < base_q) || (ptr_raw > last_q)) ? base_q : ptr_raw;

    idx_d       = idx_q;
    pidx_d      = pidx_q;
    free_d      = free_q;
    base_d      = base_q;
    last_d      = last_q;
    tag_d       = tag_q;
    second_d    = second_q;
    iss_d       = iss_q;
    pend_d      = pend_q;
    have_free_d = have_free_q;
    hit_d       = hit_q;
    line_vld_d  = line_vld_q;
    fifo1_d     = fifo1_q;
    fifo2_d     = fifo2_q;
    acc_d       = acc_q;
    hits_d      = hits_q;
    done_d      = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = pidx_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          base_d      = base;
          last_d      = last_w[LW-1:0];
          second_d    = split && req_i.access_kind;
          hit_d       = 1'b0;
          have_free_d = 1'b0;
          pend_d      = 1'b0;
          iss_d       = 1'b1;
          if (map_mode_q) begin
            tag_d  = off;
            idx_d  = base;
            pidx_d = base;
          end else begin
            tag_d  = off >> ib;
            idx_d  = slot;
            pidx_d = slot;
          end
        end
      end
      ST_DM_RD: begin
        ram_re = 1'b1;
      end
      ST_DM_CMP: begin
        hit_d = cmp_hit;
        if (!cmp_hit) begin
          ram_we             = 1'b1;
          line_vld_d[pidx_q] = 1'b1;
        end
      end
      ST_FA_SCAN: begin
        ram_re = iss_q;
        if (iss_q) begin
          pidx_d = idx_q;
          if (idx_q == last_q) begin
            iss_d = 1'b0;
          end else begin
            idx_d = idx_q + LW'(1);
          end
        end
        pend_d = iss_q;
        if (pend_q) begin
          if (cmp_hit) begin
            hit_d  = 1'b1;
            iss_d  = 1'b0;
            pend_d = 1'b0;
          end else if (!line_vld_q[pidx_q] && !have_free_q) begin
            have_free_d = 1'b1;
            free_d      = pidx_q;
          end
        end
      end
      ST_FA_FILL: begin
        ram_we = 1'b1;
        if (have_free_q) begin
          ram_waddr = free_q;
        end else begin
          ram_waddr = ptr;
          if (second_q) begin
            fifo2_d = (ptr == last_q) ? base_q : ptr + LW'(1);
          end else begin
            fifo1_d = (ptr == last_q) ? base_q : ptr + LW'(1);
          end
        end
        line_vld_d[ram_waddr] = 1'b1;
      end
      ST_FINISH: begin
        done_d = 1'b1;
        if (acc_q != '1) begin
          acc_d = acc_q + CNT_W'(1);
        end
        if (hit_q && (hits_q != '1)) begin
          hits_d = hits_q + CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      map_mode_q     <= 1'b0;
      organization_q <= 1'b0;
      blk_log2_q     <= BLK_LOG2_RST;
      line_vld_q     <= '0;
      fifo1_q        <= '0;
      fifo2_q        <= LW'(HALF);
      acc_q          <= '0;
      hits_q         <= '0;
      done_q         <= 1'b0;
      iss_q          <= 1'b0;
      pend_q         <= 1'b0;
      have_free_q    <= 1'b0;
      hit_q          <= 1'b0;
    end else begin
      state_q     <= state_d;
      line_vld_q  <= line_vld_d;
      fifo1_q     <= fifo1_d;
      fifo2_q     <= fifo2_d;
      acc_q       <= acc_d;
      hits_q      <= hits_d;
      done_q      <= done_d;
      iss_q       <= iss_d;
      pend_q      <= pend_d;
      have_free_q <= have_free_d;
      hit_q       <= hit_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_MAP_MODE:     map_mode_q     <= cfg_data_i[0];
          CFG_ORGANIZATION: organization_q <= cfg_data_i[0];
          CFG_BLOCKS_LOG2:  blk_log2_q     <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    pidx_q   <= pidx_d;
    free_q   <= free_d;
    base_q   <= base_d;
    last_q   <= last_d;
    tag_q    <= tag_d;
    second_q <= second_d;
  end

  assign done_o                = done_q;
  assign result_o.hit          = hit_q;
  assign result_o.access_total = acc_q;
  assign result_o.hit_total    = hits_q;

endmodule

@@ verif/cache_tag_lookup_fifo_checker.sv @@
// Checker for cache_tag_lookup_fifo: watches the request, result and register
// channels, predicts each lookup and compares results in order.
// Depends on ctl_pkg.
module cache_tag_lookup_fifo_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic                           busy_i,
  input  ctl_pkg::req_t                  req_i,
  input  logic                           done_i,
  input  ctl_pkg::res_t                  result_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [ctl_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ctl_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                             fail_count_o,
  output int                             pending_o,
  output int                             checked_o,
  output int                             hits_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_LINES  = 64;
  localparam int LINES_LOG2 = $clog2(MAX_LINES);
  localparam int LINE_LOG2  = $clog2(64);
  localparam logic [ctl_pkg::CNT_W-1:0] CNT_FULL = '1;

  logic [25:0]                      tag_mem [MAX_LINES];
  logic                             line_valid [MAX_LINES];
  logic [5:0]                       inst_fifo_ptr;
  logic [5:0]                       data_fifo_ptr;
  logic [ctl_pkg::CNT_W-1:0]        access_cnt;
  logic [ctl_pkg::CNT_W-1:0]        hit_cnt;
  logic                             map_mode;
  logic                             organization;
  logic [ctl_pkg::BLK_LOG2_W-1:0]   blocks_log2;

  ctl_pkg::res_t lookup_results_q [$];
  ctl_pkg::res_t want;
  int            fails;
  int            checked;
  int            hits;
  int            k;

  function automatic ctl_pkg::res_t predict_lookup(ctl_pkg::req_t rq);
    ctl_pkg::res_t rs;
    int unsigned   lb;
    int unsigned   ib;
    int unsigned   size;
    int unsigned   base;
    int unsigned   slot;
    int unsigned   free_slot;
    int unsigned   ptr;
    int unsigned   nxt;
    int unsigned   i;
    logic [25:0]   tag;
    logic          hit;
    logic          have_free;
    logic          second;
    lb = (blocks_log2 < 1) ? 1 : (blocks_log2 > LINES_LOG2) ? LINES_LOG2 : blocks_log2;
    ib = organization ? lb - 1 : lb;
    size = 1 << ib;
    second = organization && rq.access_kind;
    base = second ? size : 0;
    hit = 1'b0;
    have_free = 1'b0;
    free_slot = 0;
    if (!map_mode) begin
      slot = base + ((rq.address >> LINE_LOG2) & (size - 1));
      tag = 26'(rq.address >> (LINE_LOG2 + ib));
      if (line_valid[slot] && tag_mem[slot] == tag) begin
        hit = 1'b1;
      end else begin
        tag_mem[slot] = tag;
        line_valid[slot] = 1'b1;
      end
    end else begin
      tag = 26'(rq.address >> LINE_LOG2);
      for (i = base; i < base + size && !hit; i++) begin
        if (line_valid[i]) begin
          if (tag_mem[i] == tag) hit = 1'b1;
        end else if (!have_free) begin
          have_free = 1'b1;
          free_slot = i;
        end
      end
      if (!hit) begin
        if (have_free) begin
          tag_mem[free_slot] = tag;
          line_valid[free_slot] = 1'b1;
        end else begin
          ptr = second ? data_fifo_ptr : inst_fifo_ptr;
          // stale pointer from an earlier setting restarts at its region
          if (ptr < base || ptr >= base + size) ptr = base;
          tag_mem[ptr] = tag;
          line_valid[ptr] = 1'b1;
          nxt = ptr + 1;
          if (nxt >= base + size) nxt = base;
          if (second) data_fifo_ptr = 6'(nxt);
          else inst_fifo_ptr = 6'(nxt);
        end
      end
    end
    if (access_cnt != CNT_FULL) access_cnt = access_cnt + 1;
    if (hit && hit_cnt != CNT_FULL) hit_cnt = hit_cnt + 1;
    rs.hit = hit;
    rs.access_total = access_cnt;
    rs.hit_total = hit_cnt;
    return rs;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (k = 0; k < MAX_LINES; k++) line_valid[k] = 1'b0;
      map_mode = 1'b0;
      organization = 1'b0;
      blocks_log2 = ctl_pkg::BLK_LOG2_RST;
      inst_fifo_ptr = '0;
      data_fifo_ptr = 6'(MAX_LINES / 2);
      access_cnt = '0;
      hit_cnt = '0;
      lookup_results_q.delete();
      fails = 0;
      checked = 0;
      hits = 0;
      fail_count_o <= 0;
      pending_o <= 0;
      checked_o <= 0;
      hits_o <= 0;
    end else begin
      if (done_i) begin
        if (lookup_results_q.size() == 0) begin
          $display("%0t: result word with nothing expected, actual hit=%0d acc=%0h hits=%0h",
                   $time, result_i.hit, result_i.access_total, result_i.hit_total);
          fails++;
        end else begin
          want = lookup_results_q.pop_front();
          check_field("hit", 32'(want.hit), 32'(result_i.hit));
          check_field("access_total", want.access_total, result_i.access_total);
          check_field("hit_total", want.hit_total, result_i.hit_total);
          checked++;
          if (want.hit) hits++;
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          ctl_pkg::CFG_MAP_MODE:     map_mode = cfg_data_i[0];
          ctl_pkg::CFG_ORGANIZATION: organization = cfg_data_i[0];
          ctl_pkg::CFG_BLOCKS_LOG2:  blocks_log2 = cfg_data_i;
          default: ;
        endcase
      end
      if (start_i && !busy_i) lookup_results_q.push_back(predict_lookup(req_i));
      fail_count_o <= fails;
      pending_o <= lookup_results_q.size();
      checked_o <= checked;
      hits_o <= hits;
    end
  end

endmodule

@@ verif/cache_tag_lookup_fifo_test.sv @@
// Top of the cache_tag_lookup_fifo testbench: clock, reset, access and
// register stimulus, watchdog and verdict. Uses ctl_pkg and the checker.
module cache_tag_lookup_fifo_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ctl_pkg::*;

  localparam int STALL_LIMIT = 1000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 50;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  req_t                  req;
  logic                  done;
  res_t                  result;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fail_count;
  int pending;
  int checked;
  int hits;
  int settings;
  int stall_cycles;
  logic quiet;

  logic [25:0] line_pool [64];
  int          pool_n;

  cache_tag_lookup_fifo dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req),
    .done_o      (done),
    .result_o    (result),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  cache_tag_lookup_fifo_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .req_i        (req),
    .done_i       (done),
    .result_i     (result),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .hits_o       (hits)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (start && !busy) || done || (cfg_valid && cfg_ready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("Watchdog: no word moved for %0d cycles", STALL_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  function automatic logic [31:0] pick_addr();
    if (pool_n == 0 || $urandom_range(0, 99) < 20) return $urandom();
    return {line_pool[$urandom_range(0, pool_n - 1)], 6'($urandom_range(0, 63))};
  endfunction

  task automatic issue(input logic [31:0] addr, input logic kind);
    @(negedge clk_i);
    start = 1'b1;
    req.address = addr;
    req.access_kind = kind;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic pause(input int n);
    if (n > 0) begin
      @(negedge clk_i);
      start = 1'b0;
      req = req_t'({$urandom(), 1'($urandom())});
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  task automatic access(input logic [31:0] addr, input logic kind);
    issue(addr, kind);
    pause(pick_gap());
  endtask

  task automatic drain();
    @(negedge clk_i);
    start = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  task automatic set_mode(input logic mm, input logic org, input logic [2:0] blk);
    drain();
    write_reg(CFG_MAP_MODE, {2'($urandom()), mm});
    write_reg(CFG_ORGANIZATION, {2'($urandom()), org});
    write_reg(CFG_BLOCKS_LOG2, blk);
    settings++;
  endtask

  task automatic build_pool();
    logic [19:0] hi [3];
    int j;
    for (j = 0; j < 3; j++) hi[j] = 20'($urandom());
    pool_n = $urandom_range(2, 40);
    for (j = 0; j < pool_n; j++)
      line_pool[j] = {hi[$urandom_range(0, 2)], 6'($urandom_range(0, 63))};
  endtask

  initial begin
    logic [2:0] blk_edges [4];
    int p;
    int n;
    blk_edges[0] = 3'd7;
    blk_edges[1] = 3'd0;
    blk_edges[2] = 3'd1;
    blk_edges[3] = 3'd6;
    rst_ni = 1'b0;
    start = 1'b0;
    req = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    settings = 1;
    quiet = 1'b0;
    pool_n = 0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset setting: direct mapped, unified, 64 lines
    access(32'h0000_0000, 1'b0);
    access(32'h0000_003F, 1'b1);
    access(32'hFFFF_FFFF, 1'b1);
    access(32'hFFFF_FFC0, 1'b0);
    access(32'h0000_1000, 1'b0);
    access(32'h0000_0000, 1'b1);
    // associative on two lines, tags kept from direct mapped, then FIFO wrap
    set_mode(1'b1, 1'b0, 3'd1);
    access(32'h0000_0000, 1'b0);
    access(32'h0000_0040, 1'b1);
    access(32'h0000_0080, 1'b0);
    access(32'h0000_00C0, 1'b1);
    access(32'h0000_0080, 1'b0);
    // line count below range, split: data pointer starts outside its half
    set_mode(1'b1, 1'b1, 3'd0);
    access(32'h0000_0080, 1'b0);
    access(32'h0000_0100, 1'b1);
    access(32'h0000_0100, 1'b1);
    access(32'h0000_0140, 1'b1);
    // line count above range, direct mapped split
    set_mode(1'b0, 1'b1, 3'd7);
    access(32'hFFFF_FFFF, 1'b1);
    access(32'hFFFF_FFFF, 1'b1);
    access(32'hFFFF_FFFF, 1'b0);
    access(32'h0000_0000, 1'b1);
    drain();
    write_reg(CFG_UNUSED, 3'($urandom()));
    access(32'h0000_0000, 1'b1);
    access(32'h5555_5555, 1'b0);
    access(32'hAAAA_AAAA, 1'b1);

    for (p = 0; p < PHASES; p++) begin
      set_mode(p[0], p[1], (p < 4) ? blk_edges[p] : 3'($urandom_range(0, 7)));
      build_pool();
      quiet = (p % 3 == 2);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        access(pick_addr(), 1'($urandom()));
        if (p == 5 && n == PHASE_ITEMS / 2) drain();
      end
    end

    drain();
    repeat (80) @(negedge clk_i);
    $display("Checked %0d lookups with %0d hits over %0d register settings",
             checked, hits, settings);
    $display("Both mapping modes, both organizations, line counts from below to above range");
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
